// File: design/pmsr_pkg.sv
// Shared types and codes for the page-mapped sector remapper.
package pmsr_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_ALLOC,
    ST_FETCH
  } state_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_UNMAPPED = 2'd1,
    STATUS_NOFREE   = 2'd2
  } status_e;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int SectorW = 10;

endpackage

// File: design/page_mapped_sector_remapper_top.sv
// Page-mapped sector remapper: map memory, free/dirty ring and request sequencer.
//
// One request (read or write of a logical sector) is taken when start_i is high and
// busy_o is low, and gives exactly one result, shown for one cycle with done_o high;
// the receiver must take it then. A read does a map lookup through the registered
// map memory. A write steps through map lookup, push of the old physical sector
// into the ring, ring read at the free head, map update; a write that finds no
// free sector, or that addresses a sector past the map, ends after the lookup.
// The ring slot adder is shared between the push slot and the head advance.
// After reset the block runs a clearing pass that clears the map valid bits and
// loads the ring with ascending sectors; busy_o stays high meanwhile.
module page_mapped_sector_remapper_top #(
  parameter int LOGICAL_SECTORS  = 1024,
  parameter int PHYSICAL_SECTORS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          op_i,
  input  logic [pmsr_pkg::SectorW-1:0]  logical_sector_i,
  output logic                          done_o,
  output logic [pmsr_pkg::SectorW-1:0]  physical_sector_o,
  output logic [1:0]                    status_o,
  output logic                          collected_o
);

  localparam int LW   = (LOGICAL_SECTORS > 1) ? $clog2(LOGICAL_SECTORS) : 1;
  localparam int PW   = (PHYSICAL_SECTORS > 1) ? $clog2(PHYSICAL_SECTORS) : 1;
  localparam int CNTW = PW + 1;
  localparam int SUMW = CNTW + 1;
  localparam int MAXS = (LOGICAL_SECTORS > PHYSICAL_SECTORS) ? LOGICAL_SECTORS
                                                             : PHYSICAL_SECTORS;
  localparam int CLW  = $clog2(MAXS);
  localparam int XLW  = (LW > pmsr_pkg::SectorW) ? LW : pmsr_pkg::SectorW;
  localparam int XPW  = (PW > pmsr_pkg::SectorW) ? PW : pmsr_pkg::SectorW;

  // Memories: map entry is {valid, physical}
  logic [PW:0]   map_mem  [LOGICAL_SECTORS];
  logic [PW-1:0] ring_mem [PHYSICAL_SECTORS];

  pmsr_pkg::state_e state_q, state_d;

  logic [CLW-1:0]  clr_q, clr_d;
  logic            op_q, op_d;
  logic [pmsr_pkg::SectorW-1:0] ls_q, ls_d;
  logic [PW-1:0]   head_q, head_d;
  logic [CNTW-1:0] free_q, free_d;
  logic [CNTW-1:0] dirty_q, dirty_d;
  logic            col_q, col_d;

  logic            done_q, done_d;
  logic [pmsr_pkg::SectorW-1:0] phys_q, phys_d;
  pmsr_pkg::status_e status_q, status_d;
  logic            colo_q, colo_d;

  logic [PW:0]     map_rd_q;
  logic [PW-1:0]   ring_rd_q;

  // memory port controls
  logic            map_re, map_we;
  logic [LW-1:0]   map_ra, map_wa;
  logic [PW:0]     map_wd;
  logic            ring_re, ring_we;
  logic [PW-1:0]   ring_ra, ring_wa, ring_wd;

  // shared ring slot unit: (head + offset) mod PHYSICAL_SECTORS, offset <= PHYSICAL_SECTORS
  logic [CNTW-1:0] slot_off;
  logic [SUMW-1:0] slot_sum;
  logic [SUMW-1:0] slot_wrap;
  logic [PW-1:0]   slot;

  logic [XLW-1:0]  ls_in_ext, ls_q_ext;
  logic [XPW-1:0]  phys_map_ext, phys_ring_ext;
  logic [SUMW-1:0] used_sum;
  logic            ls_in_range;
  logic            push;
  logic [CNTW-1:0] dirty_push;

  assign ls_in_ext   = XLW'(logical_sector_i);
  assign ls_q_ext    = XLW'(ls_q);
  assign ls_in_range = (32'(ls_q) < LOGICAL_SECTORS);

  assign phys_map_ext  = XPW'(map_rd_q[PW-1:0]);
  assign phys_ring_ext = XPW'(ring_rd_q);

  assign slot_sum  = SUMW'(head_q) + SUMW'(slot_off);
  assign slot_wrap = (slot_sum >= SUMW'(PHYSICAL_SECTORS))
                   ? (slot_sum - SUMW'(PHYSICAL_SECTORS)) : slot_sum;
  assign slot      = slot_wrap[PW-1:0];

  assign used_sum   = SUMW'(free_q) + SUMW'(dirty_q);
  assign push       = map_rd_q[PW] && (used_sum < SUMW'(PHYSICAL_SECTORS));
  assign dirty_push = dirty_q + CNTW'(push);

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    op_d     = op_q;
    ls_d     = ls_q;
    head_d   = head_q;
    free_d   = free_q;
    dirty_d  = dirty_q;
    col_d    = col_q;
    done_d   = 1'b0;
    phys_d   = phys_q;
    status_d = status_q;
    colo_d   = colo_q;

    map_re  = 1'b0;
    map_ra  = ls_in_ext[LW-1:0];
    map_we  = 1'b0;
    map_wa  = ls_q_ext[LW-1:0];
    map_wd  = {1'b1, ring_rd_q};
    ring_re = 1'b0;
    ring_ra = head_q;
    ring_we = 1'b0;
    ring_wa = slot;
    ring_wd = map_rd_q[PW-1:0];
    slot_off = used_sum[CNTW-1:0];

    unique case (state_q)
      pmsr_pkg::ST_CLEAR: begin
        map_we  = (32'(clr_q) < LOGICAL_SECTORS);
        map_wa  = clr_q[LW-1:0];
        map_wd  = '0;
        ring_we = (32'(clr_q) < PHYSICAL_SECTORS);
        ring_wa = clr_q[PW-1:0];
        ring_wd = clr_q[PW-1:0];
        clr_d   = clr_q + CLW'(1);
        if (clr_q == CLW'(MAXS - 1)) begin
          state_d = pmsr_pkg::ST_IDLE;
        end
      end
      pmsr_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d    = op_i;
          ls_d    = logical_sector_i;
          map_re  = 1'b1;
          state_d = pmsr_pkg::ST_LOOK;
        end
      end
      pmsr_pkg::ST_LOOK: begin
        if (op_q == pmsr_pkg::OP_READ) begin
          done_d  = 1'b1;
          colo_d  = 1'b0;
          state_d = pmsr_pkg::ST_IDLE;
          if (ls_in_range && map_rd_q[PW]) begin
            phys_d   = phys_map_ext[pmsr_pkg::SectorW-1:0];
            status_d = pmsr_pkg::STATUS_OK;
          end else begin
            phys_d   = '0;
            status_d = pmsr_pkg::STATUS_UNMAPPED;
          end
        end else if (!ls_in_range) begin
          done_d   = 1'b1;
          phys_d   = '0;
          status_d = pmsr_pkg::STATUS_NOFREE;
          colo_d   = 1'b0;
          state_d  = pmsr_pkg::ST_IDLE;
        end else begin
          // old sector goes to the tail of the dirty region
          ring_we = push;
          dirty_d = dirty_push;
          col_d   = 1'b0;
          if (free_q == '0 && dirty_push != '0) begin
            // dirty region already starts at the head: relabel it free
            free_d  = dirty_push;
            dirty_d = '0;
            col_d   = 1'b1;
          end
          if (free_q == '0 && dirty_push == '0) begin
            done_d   = 1'b1;
            phys_d   = '0;
            status_d = pmsr_pkg::STATUS_NOFREE;
            colo_d   = 1'b0;
            state_d  = pmsr_pkg::ST_IDLE;
          end else begin
            state_d = pmsr_pkg::ST_ALLOC;
          end
        end
      end
      pmsr_pkg::ST_ALLOC: begin
        ring_re  = 1'b1;
        slot_off = CNTW'(1);
        head_d   = slot;
        free_d   = free_q - CNTW'(1);
        state_d  = pmsr_pkg::ST_FETCH;
      end
      pmsr_pkg::ST_FETCH: begin
        map_we   = 1'b1;
        done_d   = 1'b1;
        phys_d   = phys_ring_ext[pmsr_pkg::SectorW-1:0];
        status_d = pmsr_pkg::STATUS_OK;
        colo_d   = col_q;
        state_d  = pmsr_pkg::ST_IDLE;
      end
      default: begin
        state_d = pmsr_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmsr_pkg::ST_CLEAR;
      clr_q   <= '0;
      head_q  <= '0;
      free_q  <= CNTW'(PHYSICAL_SECTORS);
      dirty_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      head_q  <= head_d;
      free_q  <= free_d;
      dirty_q <= dirty_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    ls_q     <= ls_d;
    col_q    <= col_d;
    phys_q   <= phys_d;
    status_q <= status_d;
    colo_q   <= colo_d;
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (map_re) begin
      map_rd_q <= map_mem[map_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[ring_ra];
    end
  end

  assign busy_o            = (state_q != pmsr_pkg::ST_IDLE);
  assign done_o            = done_q;
  assign physical_sector_o = phys_q;
  assign status_o          = status_q;
  assign collected_o       = colo_q;

endmodule

// File: sim/tb.sv
// Testbench for the page-mapped sector remapper: random and directed requests vs a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumLogical  = 1024;
  localparam int NumPhysical = 1024;

  typedef struct packed {
    logic [pmsr_pkg::SectorW-1:0] phys;
    pmsr_pkg::status_e            status;
    logic                         collected;
  } remap_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start_i = 1'b0;
  logic                         op_i = 1'b0;
  logic [pmsr_pkg::SectorW-1:0] logical_sector_i = '0;
  logic                         busy_o;
  logic                         done_o;
  logic [pmsr_pkg::SectorW-1:0] physical_sector_o;
  logic [1:0]                   status_o;
  logic                         collected_o;

  page_mapped_sector_remapper_top #(
    .LOGICAL_SECTORS (NumLogical),
    .PHYSICAL_SECTORS(NumPhysical)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .logical_sector_i (logical_sector_i),
    .done_o           (done_o),
    .physical_sector_o(physical_sector_o),
    .status_o         (status_o),
    .collected_o      (collected_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the map and the free/dirty ring
  logic                         lmap_valid [NumLogical];
  logic [pmsr_pkg::SectorW-1:0] lmap_phys  [NumLogical];
  logic [pmsr_pkg::SectorW-1:0] sector_ring[NumPhysical];
  int unsigned                  free_head;
  int unsigned                  free_count;
  int unsigned                  dirty_count;

  remap_result_t expected_results[$];
  int            mismatch_count = 0;
  bit            steady = 1'b0;

  function automatic remap_result_t remap_predict(logic op,
                                                  logic [pmsr_pkg::SectorW-1:0] ls);
    remap_result_t r;
    int unsigned   slot;
    r = '{phys: '0, status: pmsr_pkg::STATUS_OK, collected: 1'b0};
    if (op == pmsr_pkg::OP_READ) begin
      if (ls < NumLogical && lmap_valid[ls]) r.phys = lmap_phys[ls];
      else r.status = pmsr_pkg::STATUS_UNMAPPED;
      return r;
    end
    if (ls >= NumLogical) begin
      r.status = pmsr_pkg::STATUS_NOFREE;
      return r;
    end
    // old sector goes to the tail of the dirty region
    if (lmap_valid[ls] && free_count + dirty_count < NumPhysical) begin
      slot = (free_head + free_count + dirty_count) % NumPhysical;
      sector_ring[slot] = lmap_phys[ls];
      dirty_count++;
    end
    // dirty region already starts at the free head: relabel it as free
    if (free_count == 0 && dirty_count != 0) begin
      free_count  = dirty_count;
      dirty_count = 0;
      r.collected = 1'b1;
    end
    if (free_count == 0) begin
      r.status = pmsr_pkg::STATUS_NOFREE;
      return r;
    end
    r.phys     = sector_ring[free_head];
    free_head  = (free_head + 1) % NumPhysical;
    free_count--;
    lmap_valid[ls] = 1'b1;
    lmap_phys[ls]  = r.phys;
    return r;
  endfunction

  // called right after a rising edge; returns right after the accepting edge or a gap
  task automatic issue_request(input logic op, input logic [pmsr_pkg::SectorW-1:0] ls);
    start_i          <= 1'b1;
    op_i             <= op;
    logical_sector_i <= ls;
    do @(posedge clk_i); while (busy_o);
    expected_results.push_back(remap_predict(op, ls));
    if (!steady && $urandom_range(0, 99) < 28) begin
      start_i          <= 1'b0;
      op_i             <= 1'($urandom_range(0, 1));
      logical_sector_i <= pmsr_pkg::SectorW'($urandom_range(0, NumLogical - 1));
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    issue_request(pmsr_pkg::OP_READ, 10'd0);
    issue_request(pmsr_pkg::OP_READ, 10'd1023);
    issue_request(pmsr_pkg::OP_WRITE, 10'd0);
    issue_request(pmsr_pkg::OP_READ, 10'd0);
    issue_request(pmsr_pkg::OP_WRITE, 10'd0);    // rewrite: old sector becomes dirty
    issue_request(pmsr_pkg::OP_READ, 10'd0);
    issue_request(pmsr_pkg::OP_WRITE, 10'd1023);
    issue_request(pmsr_pkg::OP_READ, 10'd1023);
    issue_request(pmsr_pkg::OP_WRITE, 10'h155);
    issue_request(pmsr_pkg::OP_WRITE, 10'h2AA);
    issue_request(pmsr_pkg::OP_READ, 10'h155);
    issue_request(pmsr_pkg::OP_READ, 10'h2AA);
    issue_request(pmsr_pkg::OP_READ, 10'h200);   // never written
    issue_request(pmsr_pkg::OP_WRITE, 10'h155);
    issue_request(pmsr_pkg::OP_READ, 10'h155);
    issue_request(pmsr_pkg::OP_READ, 10'h3FE);
  endtask

  // rewrites concentrate on a hot set so the dirty list grows
  task automatic test_hot_traffic(input int count);
    logic                         op;
    logic [pmsr_pkg::SectorW-1:0] ls;
    repeat (count) begin
      op = ($urandom_range(0, 99) < 60) ? pmsr_pkg::OP_WRITE : pmsr_pkg::OP_READ;
      ls = pmsr_pkg::SectorW'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, NumLogical - 1));
      issue_request(op, ls);
    end
  endtask

  // writes every logical sector: runs the free list dry, collects, ends fully mapped
  task automatic test_full_sweep();
    for (int i = 0; i < NumLogical; i++) begin
      steady = (i < NumLogical / 2);
      issue_request(pmsr_pkg::OP_WRITE, i[pmsr_pkg::SectorW-1:0]);
    end
    steady = 1'b0;
  endtask

  // fully mapped: each write collects its own just-freed sector
  task automatic test_collect_each_write(input int count);
    repeat (count)
      issue_request($urandom_range(0, 1) ? pmsr_pkg::OP_WRITE : pmsr_pkg::OP_READ,
                    pmsr_pkg::SectorW'($urandom_range(0, NumLogical - 1)));
  endtask

  always @(posedge clk_i) begin
    remap_result_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: phys %0d status %0d collected %0d",
               physical_sector_o, status_o, collected_o);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (physical_sector_o !== exp_r.phys) begin
          $error("physical_sector: expected %0d, got %0d", exp_r.phys, physical_sector_o);
          mismatch_count++;
        end
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          mismatch_count++;
        end
        if (collected_o !== exp_r.collected) begin
          $error("collected: expected %0d, got %0d", exp_r.collected, collected_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NumLogical; i++) begin
      lmap_valid[i] = 1'b0;
      lmap_phys[i]  = '0;
    end
    for (int i = 0; i < NumPhysical; i++) sector_ring[i] = i[pmsr_pkg::SectorW-1:0];
    free_head   = 0;
    free_count  = NumPhysical;
    dirty_count = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_hot_traffic(700);
    drain_results();
    repeat ($urandom_range(1, 5)) @(posedge clk_i);
    test_full_sweep();
    test_collect_each_write(160);
    drain_results();
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
